### src/qenc_pkg.sv
package qenc_pkg;

  localparam int DEF_COUNT_WIDTH = 16;

  localparam int DETENT_W   = 4;
  localparam int TICKS_W    = 16;
  localparam int STEP_SUM_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DETENT_W-1:0] RST_STEPS_PER_DETENT = 4'd4;
  localparam logic [TICKS_W-1:0]  RST_RELEASE_DEBOUNCE = 16'd50;
  localparam logic [TICKS_W-1:0]  RST_LONG_PRESS       = 16'd500;

  // Both pins high: the encoder rests there between detents.
  localparam logic [1:0] RST_PHASE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEPS_PER_DETENT = 2'd0,
    CFG_RELEASE_DEBOUNCE = 2'd1,
    CFG_LONG_PRESS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_CW   = 2'd1,
    ROT_CCW  = 2'd2
  } rot_evt_t;

  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_SHORT = 2'd1,
    KEY_LONG  = 2'd2
  } key_evt_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_dir_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic key_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0] rotation_event;
    logic [1:0] key_event;
  } out_word_t;

  typedef struct packed {
    logic [TICKS_W-1:0] release_debounce_ticks;
    logic [TICKS_W-1:0] long_press_ticks;
  } key_cfg_t;

  // Gray transition table, indexed by {old phase, new phase}.
  function automatic step_dir_t gray_step(input logic [1:0] old_p, input logic [1:0] new_p);
    step_dir_t d;
    d = STEP_NONE;
    unique case ({old_p, new_p})
      4'd1, 4'd7, 4'd8, 4'd14:  d = STEP_UP;
      4'd2, 4'd4, 4'd11, 4'd13: d = STEP_DOWN;
      default:                  d = STEP_NONE;
    endcase
    return d;
  endfunction

endpackage

### src/qenc_key.sv
module qenc_key import qenc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  logic     key_level,
  input  key_cfg_t cfg,
  output key_evt_t key_evt
);

  localparam int CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic                   key_prev_r, key_prev_nxt;
  logic                   key_held_r, key_held_nxt;
  logic                   long_done_r, long_done_nxt;
  logic                   release_pending_r, release_pending_nxt;
  logic [COUNT_WIDTH-1:0] hold_count_r, hold_count_nxt;
  logic [COUNT_WIDTH-1:0] release_count_r, release_count_nxt;

  always_comb begin
    key_evt             = KEY_NONE;
    key_held_nxt        = key_held_r;
    long_done_nxt       = long_done_r;
    release_pending_nxt = release_pending_r;
    hold_count_nxt      = hold_count_r;
    release_count_nxt   = release_count_r;

    // counters advance first, saturating
    if (key_held_r && hold_count_r != CNT_MAX) begin
      hold_count_nxt = hold_count_r + 1'b1;
    end
    if (release_pending_r && release_count_r != CNT_MAX) begin
      release_count_nxt = release_count_r + 1'b1;
    end

    // press start on falling edge, ignored while already held
    if (key_prev_r && !key_level && !key_held_r) begin
      key_held_nxt        = 1'b1;
      hold_count_nxt      = '0;
      long_done_nxt       = 1'b0;
      release_pending_nxt = 1'b0;
    end
    key_prev_nxt = key_level;

    if (key_held_nxt && key_level) begin
      if (!release_pending_nxt) begin
        release_pending_nxt = 1'b1;
        release_count_nxt   = '0;
      end else if (CMP_W'(release_count_nxt) >= CMP_W'(cfg.release_debounce_ticks)) begin
        key_held_nxt        = 1'b0;
        release_pending_nxt = 1'b0;
        if (!long_done_nxt) begin
          key_evt = KEY_SHORT;
        end
      end
    end else if (key_held_nxt) begin
      release_pending_nxt = 1'b0;
    end

    if (key_held_nxt && !long_done_nxt && !release_pending_nxt &&
        CMP_W'(hold_count_nxt) >= CMP_W'(cfg.long_press_ticks)) begin
      long_done_nxt = 1'b1;
      key_evt       = KEY_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_prev_r        <= 1'b1;
      key_held_r        <= 1'b0;
      long_done_r       <= 1'b0;
      release_pending_r <= 1'b0;
      hold_count_r      <= '0;
      release_count_r   <= '0;
    end else if (advance) begin
      key_prev_r        <= key_prev_nxt;
      key_held_r        <= key_held_nxt;
      long_done_r       <= long_done_nxt;
      release_pending_r <= release_pending_nxt;
      hold_count_r      <= hold_count_nxt;
      release_count_r   <= release_count_nxt;
    end
  end

  a_pending_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    release_pending_r |-> key_held_r)
    else $error("release pending without a held key");

  a_long_marks_done: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && key_evt == KEY_LONG) |=> long_done_r)
    else $error("long press emitted but not recorded");

  a_short_frees_key: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && key_evt == KEY_SHORT) |=> !key_held_r)
    else $error("short press emitted but key still held");

endmodule

### src/quadrature_encoder_with_button.sv
// Quadrature encoder decoder with push key.
//
// Input channel (in_valid / in_stall / in_data): one word per sample tick,
// carrying pin_a, pin_b and the active-low key_level. A word is taken on a
// rising edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall / out_data): a word is produced only
// for ticks that raise a rotation detent, a key event, or both; fields with
// no event read 0.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; index 0 steps per detent, 1 release debounce ticks, 2 long press
// ticks. Other indexes are dropped. Write only while the block is idle.
//
// A result shows up on out_data the cycle after its input word is taken.
// Throughput is one word per cycle, set by the single
// output register; the input side stalls only while that register holds a
// word the receiver is stalling on, and taking the held word frees the slot
// in the same cycle.
// Synchronous reset loads the register defaults (4, 50, 500), puts the
// phase at both pins high and the key logic at released / idle.
module quadrature_encoder_with_button import qenc_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [DETENT_W-1:0] steps_per_detent_r;
  logic [TICKS_W-1:0]  release_debounce_r;
  logic [TICKS_W-1:0]  long_press_r;
  key_cfg_t            key_cfg;

  // rotation state
  logic [1:0]                   phase_r;
  logic signed [STEP_SUM_W-1:0] step_sum_r, step_sum_nxt;
  logic [1:0]                   phase_nxt;
  step_dir_t                    dir;
  logic signed [STEP_SUM_W:0]   sum_ext;
  logic signed [STEP_SUM_W:0]   lim_ext;
  rot_evt_t                     rot_evt;
  key_evt_t                     key_evt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r, out_data_nxt;
  logic      accept;
  logic      has_event;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_per_detent_r <= RST_STEPS_PER_DETENT;
      release_debounce_r <= RST_RELEASE_DEBOUNCE;
      long_press_r       <= RST_LONG_PRESS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STEPS_PER_DETENT: steps_per_detent_r <= cfg_data[DETENT_W-1:0];
        CFG_RELEASE_DEBOUNCE: release_debounce_r <= cfg_data[TICKS_W-1:0];
        CFG_LONG_PRESS:       long_press_r       <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_cfg.release_debounce_ticks = release_debounce_r;
  assign key_cfg.long_press_ticks       = long_press_r;

  // one output slot; it frees up in the same cycle it is drained
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // rotation decode: table step, accumulate, fire at +/- limit
  assign phase_nxt = {in_data.pin_b, in_data.pin_a};
  assign dir       = gray_step(phase_r, phase_nxt);
  assign lim_ext   = $signed({2'b00, steps_per_detent_r});

  always_comb begin
    rot_evt      = ROT_NONE;
    step_sum_nxt = step_sum_r;
    sum_ext      = {step_sum_r[STEP_SUM_W-1], step_sum_r};
    if (dir == STEP_UP) begin
      sum_ext = sum_ext + 6'sd1;
    end else if (dir == STEP_DOWN) begin
      sum_ext = sum_ext - 6'sd1;
    end
    if (dir != STEP_NONE) begin
      step_sum_nxt = sum_ext[STEP_SUM_W-1:0];
      if (sum_ext >= lim_ext) begin
        step_sum_nxt = '0;
        rot_evt      = ROT_CW;
      end else if (sum_ext <= -lim_ext) begin
        step_sum_nxt = '0;
        rot_evt      = ROT_CCW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= RST_PHASE;
      step_sum_r <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      step_sum_r <= step_sum_nxt;
    end
  end

  qenc_key #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (accept),
    .key_level (in_data.key_level),
    .cfg       (key_cfg),
    .key_evt   (key_evt)
  );

  // result word
  assign has_event = (rot_evt != ROT_NONE) || (key_evt != KEY_NONE);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt               = has_event;
      out_data_nxt.rotation_event = rot_evt;
      out_data_nxt.key_event      = key_evt;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_word_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.rotation_event != ROT_NONE ||
                     out_data_r.key_event != KEY_NONE))
    else $error("result word carries no event");

  a_detent_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rot_evt != ROT_NONE) |=> step_sum_r == '0)
    else $error("step sum not cleared after detent");

  a_phase_follows_pins: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> phase_r == $past(phase_nxt))
    else $error("phase did not track accepted pins");

endmodule

### tb/tb_quadrature_encoder_with_button.sv
`timescale 1ns / 1ps

module tb_quadrature_encoder_with_button;
  import qenc_pkg::*;

  // Index 3 maps to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam int LIMIT_NS = 100_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  quadrature_encoder_with_button DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Decoder mirror: register copies and state, at the block's widths.
  // ---------------------------------------------------------------------
  logic [DETENT_W-1:0]        detent_steps = 4'd4;
  logic [TICKS_W-1:0]         debounce_ticks = 16'd50;
  logic [TICKS_W-1:0]         long_ticks = 16'd500;

  logic [1:0]                 cur_phase = 2'd3;
  logic signed [STEP_SUM_W-1:0] step_sum = '0;
  logic                       key_prev = 1'b1;
  logic                       key_held = 1'b0;
  logic                       long_done = 1'b0;
  logic                       release_pending = 1'b0;
  logic [DEF_COUNT_WIDTH-1:0] hold_cnt = '0;
  logic [DEF_COUNT_WIDTH-1:0] release_cnt = '0;

  out_word_t event_queue[$];   // events still owed by the block, oldest first
  out_word_t want;
  int        fail_count = 0;
  bit        no_idle = 1'b0;   // set: neither side inserts bubbles

  // Stimulus generator state: position on the Gray ring, turning direction,
  // key level and how many more ticks it stays there.
  logic [1:0] gen_pos = 2'd2;
  logic [1:0] gen_turn = 2'd1;
  logic       gen_key = 1'b1;
  int         key_run = 0;

  // Ring position 0,1,2,3 <-> phase 0,1,3,2; the same map works both ways.
  function automatic logic [1:0] ring_map(input logic [1:0] v);
    return {v[1], ^v};
  endfunction

  // +1 one step forward on the ring, -1 one step back, 0 for hold or skip.
  function automatic int quarter_step(input logic [1:0] from_ph, input logic [1:0] to_ph);
    logic [1:0] d;
    d = ring_map(to_ph) - ring_map(from_ph);
    if (d == 2'd1) return 1;
    if (d == 2'd3) return -1;
    return 0;
  endfunction

  function automatic in_word_t pack_word(input logic [1:0] ph, input logic key);
    in_word_t w;
    w.pin_a     = ph[0];
    w.pin_b     = ph[1];
    w.key_level = key;
    return w;
  endfunction

  // One sample tick through the mirror; queues an event word if one is due.
  task automatic decode_tick(input in_word_t w);
    logic [1:0] np;
    int         dir;
    int         sum;
    rot_evt_t   rot;
    key_evt_t   kev;
    out_word_t  e;
    np  = {w.pin_b, w.pin_a};
    dir = quarter_step(cur_phase, np);
    cur_phase = np;
    rot = ROT_NONE;
    kev = KEY_NONE;

    // rotation: sum quarter steps, fire at +/- detent_steps
    if (dir != 0) begin
      sum = int'(step_sum) + dir;
      if (sum >= int'(detent_steps)) begin
        sum = 0;
        rot = ROT_CW;
      end else if (sum <= -int'(detent_steps)) begin
        sum = 0;
        rot = ROT_CCW;
      end
      step_sum = sum[STEP_SUM_W-1:0];
    end

    // saturating tick counters
    if (key_held && hold_cnt != '1) hold_cnt = hold_cnt + 1'b1;
    if (release_pending && release_cnt != '1) release_cnt = release_cnt + 1'b1;

    // press starts on a falling edge only when not already held
    if (key_prev && !w.key_level && !key_held) begin
      key_held        = 1'b1;
      hold_cnt        = '0;
      long_done       = 1'b0;
      release_pending = 1'b0;
    end
    key_prev = w.key_level;

    // release debounce; a pressed sample cancels a pending release
    if (key_held && w.key_level) begin
      if (!release_pending) begin
        release_pending = 1'b1;
        release_cnt     = '0;
      end else if (release_cnt >= debounce_ticks) begin
        key_held        = 1'b0;
        release_pending = 1'b0;
        if (!long_done) kev = KEY_SHORT;
      end
    end else if (key_held) begin
      release_pending = 1'b0;
    end

    // long press, not checked while a release is pending
    if (key_held && !long_done && !release_pending && hold_cnt >= long_ticks) begin
      long_done = 1'b1;
      kev       = KEY_LONG;
    end

    if (rot != ROT_NONE || kev != KEY_NONE) begin
      e.rotation_event = rot;
      e.key_event      = kev;
      event_queue.push_back(e);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: check each result word against the oldest owed event, then
  // run every accepted input word through the mirror. Both handshakes are
  // sampled at the rising edge, before the block's own updates land.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (event_queue.size() == 0) begin
          $error("unexpected result word: rotation_event %0d key_event %0d",
                 out_data.rotation_event, out_data.key_event);
          fail_count++;
        end else begin
          want = event_queue.pop_front();
          if (out_data.rotation_event !== want.rotation_event) begin
            $error("rotation_event: expected %0d, actual %0d",
                   want.rotation_event, out_data.rotation_event);
            fail_count++;
          end
          if (out_data.key_event !== want.key_event) begin
            $error("key_event: expected %0d, actual %0d",
                   want.key_event, out_data.key_event);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) decode_tick(in_data);
    end
  end

  // Receiver back-pressure: random stall bursts, now and then a
  // calm stretch; nothing at all once no_idle is set.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle) begin
        if ($urandom_range(0, 5) == 0) begin
          out_stall = 1'b1;
          repeat ($urandom_range(1, 19)) @(negedge clk);
          out_stall = 1'b0;
        end else if ($urandom_range(0, 30) == 0) begin
          repeat ($urandom_range(20, 60)) @(negedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Send one sample word; returns at the edge that takes it. Valid stays
  // high afterwards; with no_idle set, words go out back to back, no bubble.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic end_stream;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Block is idle once nothing is owed and the output register has emptied.
  task automatic wait_idle;
    while (event_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_STEPS_PER_DETENT: detent_steps   = val[DETENT_W-1:0];
      CFG_RELEASE_DEBOUNCE: debounce_ticks = val[TICKS_W-1:0];
      CFG_LONG_PRESS:       long_ticks     = val[TICKS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly clean quadrature walking with direction reversals, some held
  // samples and some skipped phases.
  task automatic walk_phase(output logic [1:0] ph);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      gen_pos = gen_pos + 2'd2;
    end else if (roll >= 13) begin
      if ($urandom_range(0, 9) == 0) gen_turn = -gen_turn;
      gen_pos = gen_pos + gen_turn;
    end
    ph = ring_map(gen_pos);
  endtask

  // Key level in runs: short runs act as contact bounce, long ones as
  // real presses and releases scaled to the current thresholds.
  task automatic next_key(input int span, output logic key);
    if (key_run == 0) begin
      gen_key = ~gen_key;
      key_run = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : $urandom_range(1, span);
    end
    key_run--;
    key = gen_key;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset detent count of 4: one full turn each way, a held phase, two
  // skipped phases; then zero steps per detent fires on every step.
  task automatic test_rotation_directed;
    logic [1:0] seq[11];
    seq = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd3, 2'd0, 2'd3};
    foreach (seq[i]) send_word(pack_word(seq[i], 1'b1));
    end_stream();
    write_reg(CFG_STEPS_PER_DETENT, 16'd0);
    send_word(pack_word(2'd2, 1'b1));
    send_word(pack_word(2'd3, 1'b1));
    end_stream();
  endtask

  // Zero debounce, long press at 2: short press, long press with silent
  // release, a re-press during debounce, then a long press in the press
  // tick itself together with a rotation event.
  task automatic test_key_directed;
    logic keys[13];
    write_reg(CFG_RELEASE_DEBOUNCE, 16'd0);
    write_reg(CFG_LONG_PRESS, 16'd2);
    keys = '{1'b0, 1'b1, 1'b1,
             1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
             1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    foreach (keys[i]) send_word(pack_word(2'd3, keys[i]));
    end_stream();
    write_reg(CFG_LONG_PRESS, 16'd0);
    send_word(pack_word(2'd2, 1'b0));
    send_word(pack_word(2'd2, 1'b1));
    send_word(pack_word(2'd2, 1'b1));
    end_stream();
  endtask

  // Full-scale thresholds: the held key never gets a long press and the
  // release stays pending until the debounce drops to zero. Also an
  // unmapped index write and a detent write with junk in the upper bits.
  task automatic test_counter_limits;
    logic [1:0] ph;
    no_idle = 1'b1;
    write_reg(CFG_NO_REG, 16'hFFFF);
    write_reg(CFG_STEPS_PER_DETENT, 16'h0F08);
    write_reg(CFG_RELEASE_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_LONG_PRESS, 16'hFFFF);
    repeat (40) begin
      walk_phase(ph);
      send_word(pack_word(ph, 1'b0));
    end
    repeat (10) begin
      walk_phase(ph);
      send_word(pack_word(ph, 1'b1));
    end
    end_stream();
    // pending release is taken on the next released sample
    write_reg(CFG_RELEASE_DEBOUNCE, 16'd0);
    repeat (2) begin
      walk_phase(ph);
      send_word(pack_word(ph, 1'b1));
    end
    end_stream();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic(input int count, input logic [CFG_DATA_W-1:0] detent,
                                     input logic [CFG_DATA_W-1:0] debounce,
                                     input logic [CFG_DATA_W-1:0] long_press);
    logic [1:0] ph;
    logic       key;
    int         span;
    write_reg(CFG_STEPS_PER_DETENT, detent);
    write_reg(CFG_RELEASE_DEBOUNCE, debounce);
    write_reg(CFG_LONG_PRESS, long_press);
    span = int'(long_press) + int'(debounce) + 8;
    repeat (count) begin
      walk_phase(ph);
      next_key(span, key);
      send_word(pack_word(ph, key));
    end
    end_stream();
  endtask

  initial begin
    int guard;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = pack_word(2'd3, 1'b1);
    cfg_valid = 1'b0;
    cfg_index = CFG_STEPS_PER_DETENT;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_rotation_directed();
    test_key_directed();
    test_counter_limits();
    test_random_traffic(140, 16'd1, 16'd0, 16'd0);
    test_random_traffic(140, 16'd8, 16'd3, 16'd10);
    test_random_traffic(140, 16'd15, 16'd7, 16'd25);
    test_random_traffic(140, 16'($urandom_range(0, 15)), 16'($urandom_range(0, 12)),
                        16'($urandom_range(0, 40)));
    // closing stretch at full rate on both sides
    no_idle = 1'b1;
    test_random_traffic(140, 16'd4, 16'd2, 16'd6);

    guard = 0;
    while (event_queue.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (event_queue.size() != 0) begin
      $error("%0d expected event words never arrived", event_queue.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("quadrature_encoder_with_button regression: pass");
    end else begin
      $display("quadrature_encoder_with_button regression: fail");
    end
    $finish;
  end

  // hung handshake guard
  initial begin
    #(LIMIT_NS);
    $display("quadrature_encoder_with_button regression: fail");
    $finish;
  end

endmodule

### filelist.f
src/qenc_pkg.sv
src/qenc_key.sv
src/quadrature_encoder_with_button.sv
tb/tb_quadrature_encoder_with_button.sv
